// File: design/lle_pkg.sv
package lle_pkg;

   localparam int VALUE_W  = 32;
   localparam int LENGTH_W = 7;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_INSERT     = 3'd4;
   localparam logic [2:0] OP_DUMP       = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]                operation;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] out_value;
      logic                      last_of_run;
      logic [LENGTH_W-1:0]       length;
   } rsp_type;

endpackage

// File: design/lle_ram.sv
module lle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lle_link_store.sv
module lle_link_store #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [$clog2(DEPTH)-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [$clog2(DEPTH)-1:0] rd_data
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic [IDX_W-1:0] ram_rd_data;
   logic [IDX_W-1:0] chain_link;

   lle_ram #(
      .WIDTH(IDX_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // unwritten entries read as the free chain built at reset
   assign chain_link = (rd_addr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_addr_ff + IDX_W'(1);
   assign rd_data    = rd_valid_ff ? ram_rd_data : chain_link;

endmodule

// File: design/linked_list_engine_top.sv
// Bounded singly linked list of signed 32-bit values, CAPACITY nodes. Issue a
// transaction by raising start while busy is low; busy stays high until the
// last result has been produced. Results appear on rsp_item for one cycle with
// rsp_strobe and cannot be held off. Pop back, insert at a middle position and
// dump walk the link memory, one link per cycle; push front, push back, pop
// front and insert at the ends need no walk. Pop back of a single element and
// any transaction that is rejected or needs no memory access are answered from
// the idle state. Dump gives one result per stored value, head first, the final
// one marked with last_of_run.
module linked_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lle_pkg::req_type req_item,
   output logic            rsp_strobe,
   output lle_pkg::rsp_type rsp_item
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_TAKE     = 3'd1;
   localparam logic [2:0] S_POPF     = 3'd2;
   localparam logic [2:0] S_WALK     = 3'd3;
   localparam logic [2:0] S_INS_TAKE = 3'd4;
   localparam logic [2:0] S_INS_LINK = 3'd5;
   localparam logic [2:0] S_DUMP     = 3'd6;

   logic [2:0]       state_ff, state_in;
   lle_pkg::req_type req_ff, req_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0] next_ff, next_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic             front_ff, front_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lle_pkg::rsp_type rsp_ff, rsp_in;

   logic                         lk_we;
   logic [IDX_W-1:0]             lk_waddr, lk_wdata, lk_raddr, lk_rdata;
   logic                         val_we;
   logic [lle_pkg::VALUE_W-1:0]  val_rdata;

   logic                         emit;
   logic [1:0]                   emit_status;
   logic [lle_pkg::VALUE_W-1:0]  emit_value;
   logic                         emit_last;

   logic       is_empty, is_full, pos_bad;
   logic [7:0] pos_mag;

   lle_link_store #(
      .DEPTH(CAPACITY)
   ) u_links (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (lk_we),
      .wr_addr(lk_waddr),
      .wr_data(lk_wdata),
      .rd_addr(lk_raddr),
      .rd_data(lk_rdata)
   );

   // node values: written at the taken node, read alongside the links
   lle_ram #(
      .WIDTH(lle_pkg::VALUE_W),
      .DEPTH(CAPACITY)
   ) u_values (
      .clock  (clock),
      .wr_en  (val_we),
      .wr_addr(free_ff),
      .wr_data(req_ff.item_value),
      .rd_addr(lk_raddr),
      .rd_data(val_rdata)
   );

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign pos_mag  = {1'b0, req_item.position[6:0]};
   assign pos_bad  = req_item.position[7] || (pos_mag > 8'(count_ff));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      node_in      = node_ff;
      next_in      = next_ff;
      steps_in     = steps_ff;
      front_in     = front_ff;
      lk_we        = 1'b0;
      lk_waddr     = head_ff;
      lk_wdata     = free_ff;
      lk_raddr     = free_ff;
      val_we       = 1'b0;
      emit         = 1'b0;
      emit_status  = lle_pkg::ST_OK;
      emit_value   = '0;
      emit_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               cur_in = head_ff;
               unique case (req_item.operation) inside
                  lle_pkg::OP_PUSH_FRONT, lle_pkg::OP_PUSH_BACK: begin
                     if (is_full) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_FULL;
                     end else begin
                        front_in = (req_item.operation == lle_pkg::OP_PUSH_FRONT);
                        state_in = S_TAKE;
                     end
                  end
                  lle_pkg::OP_POP_FRONT: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_EMPTY;
                     end else begin
                        lk_raddr = head_ff;
                        state_in = S_POPF;
                     end
                  end
                  lle_pkg::OP_POP_BACK: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_EMPTY;
                     end else if (count_ff == CNT_W'(1)) begin
                        lk_we    = 1'b1;
                        lk_waddr = head_ff;
                        lk_wdata = free_ff;
                        free_in  = head_ff;
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = '0;
                        emit     = 1'b1;
                     end else begin
                        lk_raddr = head_ff;
                        steps_in = count_ff - CNT_W'(2);
                        state_in = S_WALK;
                     end
                  end
                  lle_pkg::OP_INSERT: begin
                     if (pos_bad) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_BADPOS;
                     end else if (is_full) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_FULL;
                     end else if (pos_mag == 8'd0) begin
                        front_in = 1'b1;
                        state_in = S_TAKE;
                     end else if (pos_mag == 8'(count_ff)) begin
                        front_in = 1'b0;
                        state_in = S_TAKE;
                     end else begin
                        // walk to the node just ahead of the insert point
                        lk_raddr = head_ff;
                        steps_in = CNT_W'(pos_mag - 8'd1);
                        state_in = S_WALK;
                     end
                  end
                  lle_pkg::OP_DUMP: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = lle_pkg::ST_EMPTY;
                     end else begin
                        lk_raddr = head_ff;
                        steps_in = count_ff;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         S_TAKE: begin
            // lk_rdata is the link of the free head being taken
            free_in = lk_rdata;
            val_we  = 1'b1;
            if (front_ff) begin
               if (is_empty) begin
                  tail_in = free_ff;
               end else begin
                  lk_we    = 1'b1;
                  lk_waddr = free_ff;
                  lk_wdata = head_ff;
               end
               head_in = free_ff;
            end else begin
               if (is_empty) begin
                  head_in = free_ff;
               end else begin
                  lk_we    = 1'b1;
                  lk_waddr = tail_ff;
                  lk_wdata = free_ff;
               end
               tail_in = free_ff;
            end
            count_in = count_ff + CNT_W'(1);
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         S_POPF: begin
            lk_we    = 1'b1;
            lk_waddr = head_ff;
            lk_wdata = free_ff;
            free_in  = head_ff;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = lk_rdata;
            end
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         S_WALK: begin
            // lk_rdata is the link of cur_ff
            if (steps_ff != '0) begin
               cur_in   = lk_rdata;
               lk_raddr = lk_rdata;
               steps_in = steps_ff - CNT_W'(1);
            end else if (req_ff.operation == lle_pkg::OP_POP_BACK) begin
               lk_we    = 1'b1;
               lk_waddr = tail_ff;
               lk_wdata = free_ff;
               free_in  = tail_ff;
               tail_in  = cur_ff;
               count_in = count_ff - CNT_W'(1);
               emit     = 1'b1;
               state_in = S_IDLE;
            end else begin
               next_in  = lk_rdata;
               lk_raddr = free_ff;
               state_in = S_INS_TAKE;
            end
         end
         S_INS_TAKE: begin
            node_in  = free_ff;
            free_in  = lk_rdata;
            val_we   = 1'b1;
            lk_we    = 1'b1;
            lk_waddr = free_ff;
            lk_wdata = next_ff;
            state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            lk_we    = 1'b1;
            lk_waddr = cur_ff;
            lk_wdata = node_ff;
            count_in = count_ff + CNT_W'(1);
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         S_DUMP: begin
            // one value per cycle: the fresh link feeds the next read address
            lk_raddr   = lk_rdata;
            steps_in   = steps_ff - CNT_W'(1);
            emit       = 1'b1;
            emit_value = val_rdata;
            emit_last  = (steps_ff == CNT_W'(1));
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in       = emit;
      rsp_in.status      = emit_status;
      rsp_in.out_value   = emit_value;
      rsp_in.last_of_run = emit_last;
      rsp_in.length      = lle_pkg::LENGTH_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      node_ff  <= node_in;
      next_ff  <= next_in;
      steps_ff <= steps_in;
      front_ff <= front_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      is_empty |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with nonzero head or tail");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result without a transaction in progress");

   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("transaction ended without a result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == lle_pkg::ST_EMPTY) |-> (rsp_item.length == '0))
      else $error("empty status with nonzero length");

endmodule

// File: test/linked_list_engine_top_tb.sv
module linked_list_engine_top_tb;

   localparam int NODES        = 16;
   localparam int IDX_W        = $clog2(NODES);
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   // operation codes the block does not define
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   lle_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_strobe;
   lle_pkg::rsp_type rsp_item;

   linked_list_engine_top #(.CAPACITY(NODES)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the list
   logic [lle_pkg::VALUE_W-1:0] node_data [NODES];
   logic [IDX_W-1:0]            node_next [NODES];
   logic [IDX_W-1:0]            list_head;
   logic [IDX_W-1:0]            list_tail;
   logic [IDX_W-1:0]            free_top;
   int                          list_len;

   lle_pkg::rsp_type pending_rsp [$];
   int               mismatches      = 0;
   int               sender_idle_pct = 0;
   int               stall_cycles    = 0;

   function automatic void clear_list_model();
      for (int i = 0; i < NODES; i++) begin
         node_data[i] = '0;
         node_next[i] = IDX_W'((i + 1) % NODES);
      end
      list_head = '0;
      list_tail = '0;
      free_top  = '0;
      list_len  = 0;
   endfunction

   function automatic logic [IDX_W-1:0] take_free_node(logic [lle_pkg::VALUE_W-1:0] v);
      logic [IDX_W-1:0] n;
      n = free_top;
      free_top = node_next[n];
      node_data[n] = v;
      return n;
   endfunction

   function automatic void release_node(logic [IDX_W-1:0] n);
      node_next[n] = free_top;
      free_top = n;
   endfunction

   function automatic logic [IDX_W-1:0] node_at(int steps);
      logic [IDX_W-1:0] n;
      n = list_head;
      for (int i = 0; i < steps; i++)
         n = node_next[n];
      return n;
   endfunction

   function automatic void link_front(logic [lle_pkg::VALUE_W-1:0] v);
      logic [IDX_W-1:0] n;
      n = take_free_node(v);
      if (list_len == 0)
         list_tail = n;
      else
         node_next[n] = list_head;
      list_head = n;
      list_len++;
   endfunction

   function automatic void link_back(logic [lle_pkg::VALUE_W-1:0] v);
      logic [IDX_W-1:0] n;
      n = take_free_node(v);
      if (list_len == 0)
         list_head = n;
      else
         node_next[list_tail] = n;
      list_tail = n;
      list_len++;
   endfunction

   function automatic void post_result(logic [1:0] st, logic [lle_pkg::VALUE_W-1:0] v,
                                       logic last);
      lle_pkg::rsp_type r;
      r.status      = st;
      r.out_value   = v;
      r.last_of_run = last;
      r.length      = lle_pkg::LENGTH_W'(list_len);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // updates the shadow list for one accepted transaction and queues its results
   function automatic void apply_list_op(lle_pkg::req_type item);
      logic [1:0]       st;
      logic [7:0]       pos;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] prev;
      logic             full;
      st   = lle_pkg::ST_OK;
      pos  = item.position;
      full = (list_len >= NODES);
      case (item.operation)
         lle_pkg::OP_PUSH_FRONT: begin
            if (full) st = lle_pkg::ST_FULL;
            else link_front(item.item_value);
         end
         lle_pkg::OP_PUSH_BACK: begin
            if (full) st = lle_pkg::ST_FULL;
            else link_back(item.item_value);
         end
         lle_pkg::OP_POP_FRONT: begin
            if (list_len == 0) begin
               st = lle_pkg::ST_EMPTY;
            end else begin
               n = list_head;
               list_head = node_next[n];
               release_node(n);
               list_len--;
               if (list_len == 0) begin
                  list_head = '0;
                  list_tail = '0;
               end
            end
         end
         lle_pkg::OP_POP_BACK: begin
            if (list_len == 0) begin
               st = lle_pkg::ST_EMPTY;
            end else if (list_len == 1) begin
               release_node(list_head);
               list_len  = 0;
               list_head = '0;
               list_tail = '0;
            end else begin
               prev = node_at(list_len - 2);
               release_node(list_tail);
               list_tail = prev;
               list_len--;
            end
         end
         lle_pkg::OP_INSERT: begin
            // position range is checked ahead of the full check
            if (pos[7] || pos > list_len) begin
               st = lle_pkg::ST_BADPOS;
            end else if (full) begin
               st = lle_pkg::ST_FULL;
            end else if (pos == 0) begin
               link_front(item.item_value);
            end else if (pos == list_len) begin
               link_back(item.item_value);
            end else begin
               prev = node_at(pos - 1);
               n = take_free_node(item.item_value);
               node_next[n] = node_next[prev];
               node_next[prev] = n;
               list_len++;
            end
         end
         lle_pkg::OP_DUMP: begin
            if (list_len == 0) begin
               post_result(lle_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               n = list_head;
               for (int k = 0; k < list_len; k++) begin
                  post_result(lle_pkg::ST_OK, node_data[n], k == list_len - 1);
                  n = node_next[n];
               end
            end
            return;
         end
         default: ;
      endcase
      post_result(st, '0, 1'b1);
   endfunction

   // start is left high on return so a back-to-back transaction needs no extra edge
   task automatic send_item(input lle_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      apply_list_op(item);
   endtask

   task automatic send_op(input logic [2:0] op, input logic [lle_pkg::VALUE_W-1:0] v,
                          input logic [7:0] pos);
      lle_pkg::req_type r;
      r.operation  = op;
      r.item_value = v;
      r.position   = pos;
      send_item(r);
   endtask

   task automatic test_empty_list();
      send_op(lle_pkg::OP_POP_FRONT, 32'h0000_0001, 8'h00);
      send_op(lle_pkg::OP_POP_BACK,  32'h0000_0002, 8'h00);
      send_op(lle_pkg::OP_DUMP,      32'h0000_0003, 8'h00);
      send_op(lle_pkg::OP_INSERT,    32'h1234_5678, 8'hFF);
      send_op(lle_pkg::OP_INSERT,    32'h1234_5678, 8'h80);
      send_op(lle_pkg::OP_INSERT,    32'h1234_5678, 8'h01);
      send_op(OP_SPARE_6,            32'hFFFF_FFFF, 8'h7F);
      send_op(OP_SPARE_7,            32'hFFFF_FFFF, 8'hFF);
   endtask

   task automatic test_build_and_dump();
      send_op(lle_pkg::OP_INSERT,     32'h8000_0000, 8'h00);
      send_op(lle_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 8'hFF);
      send_op(lle_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 8'h80);
      send_op(lle_pkg::OP_INSERT,     32'h0000_0000, 8'h01);
      send_op(lle_pkg::OP_INSERT,     32'h5555_5555, 8'h04);
      send_op(lle_pkg::OP_DUMP,       32'hAAAA_AAAA, 8'h00);
   endtask

   task automatic test_unwind();
      send_op(lle_pkg::OP_POP_FRONT, '0, 8'h00);
      send_op(lle_pkg::OP_POP_BACK,  '0, 8'h00);
      send_op(lle_pkg::OP_POP_BACK,  '0, 8'h00);
      send_op(lle_pkg::OP_POP_BACK,  '0, 8'h00);
      // single element left: pop back empties the list
      send_op(lle_pkg::OP_POP_BACK,  '0, 8'h00);
      send_op(lle_pkg::OP_DUMP,      '0, 8'h00);
   endtask

   // alternates fill and drain runs so both the full and the empty list get hit
   task automatic test_random_traffic(input int n_items, input int idle_pct);
      lle_pkg::req_type r;
      int               pick;
      bit               growing;
      sender_idle_pct = idle_pct;
      growing = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         pick         = $urandom_range(99);
         r.item_value = $urandom;
         r.position   = 8'($urandom_range(0, list_len + 1));
         if (pick < 8) begin
            r.operation = lle_pkg::OP_DUMP;
         end else if (pick < 11) begin
            r.operation = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
            r.position  = 8'($urandom);
         end else if (pick < 16) begin
            r.operation = lle_pkg::OP_INSERT;
            r.position  = 8'($urandom);
         end else if (growing) begin
            case ($urandom_range(2))
               0: r.operation = lle_pkg::OP_PUSH_FRONT;
               1: r.operation = lle_pkg::OP_PUSH_BACK;
               default: r.operation = lle_pkg::OP_INSERT;
            endcase
         end else begin
            r.operation = $urandom_range(1) ? lle_pkg::OP_POP_BACK : lle_pkg::OP_POP_FRONT;
         end
         send_item(r);
         if (growing && list_len == NODES && $urandom_range(2) == 0)
            growing = 1'b0;
         else if (!growing && list_len == 0 && $urandom_range(1) == 0)
            growing = 1'b1;
         else if ($urandom_range(99) < 3)
            growing = !growing;
      end
   endtask

   always @(posedge clock) begin : check_results
      lle_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: status %0d value %0d last %0b length %0d",
                   rsp_item.status, rsp_item.out_value, rsp_item.last_of_run,
                   rsp_item.length);
            mismatches++;
         end else begin
            want = pending_rsp[0];
            pending_rsp.delete(0);
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               mismatches++;
            end
            if (rsp_item.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value,
                      rsp_item.out_value);
               mismatches++;
            end
            if (rsp_item.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                      rsp_item.last_of_run);
               mismatches++;
            end
            if (rsp_item.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_item.length);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      clear_list_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 14;
      test_empty_list();
      test_build_and_dump();
      test_unwind();
      test_random_traffic(64, 14);
      test_random_traffic(64, 54);
      test_random_traffic(64, 0);
      start <= 1'b0;

      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: linked_list_engine_top.f
design/lle_pkg.sv
design/lle_ram.sv
design/lle_link_store.sv
design/linked_list_engine_top.sv
test/linked_list_engine_top_tb.sv
